@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is active
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that is also checked while reset is active
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/uhof_pkg.sv @@
// types, codes and helpers for the usb host os fingerprint block
`timescale 1ns / 1ps

package uhof_pkg;

    // stream and config port widths
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LAYER_W = 5;
    localparam int COUNT_W = 8;
    localparam int LEN_W   = 16;
    localparam int IDLE_W  = 12;
    localparam int SETTLE_W = 16;
    localparam int GAP_W   = 12;

    // operation codes carried in the slave tuser
    localparam logic [1:0] OP_SETUP      = 2'd0;
    localparam logic [1:0] OP_TICK       = 2'd1;
    localparam logic [1:0] OP_DISCONNECT = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LAYER_MACOS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LAYER_IOS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LAYER_WINDOWS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LAYER_LINUX   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_MS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_MS        = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERT_EN     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DISC_LAYER    = 3'd7;

    // register reset values
    localparam logic [SETTLE_W-1:0] SETTLE_MS_RST = 16'd200;
    localparam logic [GAP_W-1:0]    GAP_MS_RST    = 12'd2000;

    // setup packet match: device-to-host standard descriptor fetch for a string
    localparam logic [7:0] REQ_TYPE_IN_STD_DEV = 8'h80;
    localparam logic [7:0] REQ_DESC_FETCH      = 8'h06;
    localparam logic [7:0] DESC_TYPE_STRING    = 8'h03;

    // fingerprinted lengths
    localparam logic [LEN_W-1:0] LEN_2   = 16'h0002;
    localparam logic [LEN_W-1:0] LEN_4   = 16'h0004;
    localparam logic [LEN_W-1:0] LEN_255 = 16'h00FF;

    localparam logic [IDLE_W-1:0]  IDLE_MAX  = 12'hFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // result cause flag
    localparam logic CAUSE_DETECT = 1'b0;
    localparam logic CAUSE_REVERT = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_LINUX   = 3'd1,
        KIND_WINDOWS = 3'd2,
        KIND_MACOS   = 3'd3,
        KIND_IOS     = 3'd4
    } kind_t;

    // saturating increment of a request counter
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
    endfunction

endpackage

@@ rtl/usb_host_os_fingerprint.sv @@
// top level of the usb host os fingerprint block
`timescale 1ns / 1ps

// Watches setup packets, millisecond ticks and disconnects on the slave stream
// and emits a default-layer switch on the master stream once the host has been
// classified from its string descriptor request lengths, and a revert switch
// on a disconnect after a detection when revert is enabled. One transfer is
// taken every cycle while the output register can take a result: the slave
// transfer lands in an input register, and when it advances the counters, the
// settle timer and the classifier update in one step and a result, if any, is
// loaded into the output register. The output register decouples the two
// sides, so a stalled master only stops intake once both registers are full.
// Configuration writes must happen while the block is idle.
module usb_host_os_fingerprint (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [uhof_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uhof_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // request_type, request_code, value_word, length_word, usb_connected, zero pad
    input  logic [uhof_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [uhof_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // new_layer, zero pad
    output logic [uhof_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // cause, host_kind
    output logic [uhof_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import uhof_pkg::*;

    // configuration registers
    logic [LAYER_W-1:0]  layer_macos_reg;
    logic [LAYER_W-1:0]  layer_ios_reg;
    logic [LAYER_W-1:0]  layer_windows_reg;
    logic [LAYER_W-1:0]  layer_linux_reg;
    logic [SETTLE_W-1:0] settle_ms_reg;
    logic [GAP_W-1:0]    gap_ms_reg;
    logic                revert_en_reg;
    logic [LAYER_W-1:0]  disc_layer_reg;

    // input register
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [7:0]         in_rtype_reg;
    logic [7:0]         in_rcode_reg;
    logic [15:0]        in_value_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic               in_conn_reg;

    // fingerprint state
    logic [COUNT_W-1:0]  req_count_reg,  req_count_next;
    logic [COUNT_W-1:0]  cnt_len2_reg,   cnt_len2_next;
    logic [COUNT_W-1:0]  cnt_len4_reg,   cnt_len4_next;
    logic [COUNT_W-1:0]  cnt_len255_reg, cnt_len255_next;
    logic [LEN_W-1:0]    last_len_reg,   last_len_next;
    logic [IDLE_W-1:0]   idle_reg,       idle_next;
    logic [SETTLE_W-1:0] settle_left_reg, settle_left_next;
    logic                settle_pend_reg, settle_pend_next;
    logic                switched_reg,   switched_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [LAYER_W-1:0] out_layer_reg, out_layer_next;
    logic               out_cause_reg, out_cause_next;
    kind_t              out_kind_reg,  out_kind_next;

    logic  advance;
    logic  setup_hit;
    logic  gap_clear;
    kind_t kind_c;
    logic [LAYER_W-1:0] kind_layer;

    // the stage advances when the output register is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - LAYER_W){1'b0}}, out_layer_reg};
    assign m_axis_tuser  = {out_kind_reg, out_cause_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_macos_reg   <= '0;
            layer_ios_reg     <= '0;
            layer_windows_reg <= '0;
            layer_linux_reg   <= '0;
            settle_ms_reg     <= SETTLE_MS_RST;
            gap_ms_reg        <= GAP_MS_RST;
            revert_en_reg     <= 1'b0;
            disc_layer_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LAYER_MACOS:   layer_macos_reg   <= cfg_wdata[LAYER_W-1:0];
                REG_LAYER_IOS:     layer_ios_reg     <= cfg_wdata[LAYER_W-1:0];
                REG_LAYER_WINDOWS: layer_windows_reg <= cfg_wdata[LAYER_W-1:0];
                REG_LAYER_LINUX:   layer_linux_reg   <= cfg_wdata[LAYER_W-1:0];
                REG_SETTLE_MS:     settle_ms_reg     <= cfg_wdata[SETTLE_W-1:0];
                REG_GAP_MS:        gap_ms_reg        <= cfg_wdata[GAP_W-1:0];
                REG_REVERT_EN:     revert_en_reg     <= cfg_wdata[0];
                REG_DISC_LAYER:    disc_layer_reg    <= cfg_wdata[LAYER_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register: valid is control, fields are plain payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg    <= s_axis_tuser[1:0];
            in_rtype_reg <= s_axis_tdata[7:0];
            in_rcode_reg <= s_axis_tdata[15:8];
            in_value_reg <= s_axis_tdata[31:16];
            in_len_reg   <= s_axis_tdata[47:32];
            in_conn_reg  <= s_axis_tdata[48];
        end
    end

    // host classification from the current counts, in priority order
    always_comb
    begin
        if (req_count_reg < COUNT_W'(3))
            kind_c = KIND_NONE;
        else if (cnt_len255_reg >= COUNT_W'(2) && cnt_len4_reg != '0)
            kind_c = KIND_WINDOWS;
        else if (req_count_reg == cnt_len255_reg)
            kind_c = KIND_LINUX;
        else if (req_count_reg >= COUNT_W'(5) && last_len_reg == LEN_255 &&
                 cnt_len255_reg != '0 && cnt_len2_reg >= COUNT_W'(2))
            kind_c = KIND_MACOS;
        else if (req_count_reg == COUNT_W'(4) && cnt_len255_reg == '0 &&
                 cnt_len2_reg == COUNT_W'(2))
            kind_c = KIND_IOS;
        else if (cnt_len255_reg == '0 && cnt_len2_reg == COUNT_W'(3) &&
                 cnt_len4_reg == COUNT_W'(1))
            kind_c = KIND_LINUX;
        else if (cnt_len255_reg != '0 && cnt_len2_reg == '0 && cnt_len4_reg == '0)
            kind_c = KIND_LINUX;
        else
            kind_c = KIND_NONE;
    end

    always_comb
    begin
        case (kind_c)
            KIND_MACOS:   kind_layer = layer_macos_reg;
            KIND_IOS:     kind_layer = layer_ios_reg;
            KIND_WINDOWS: kind_layer = layer_windows_reg;
            default:      kind_layer = layer_linux_reg;
        endcase
    end

    assign setup_hit = (in_rtype_reg == REQ_TYPE_IN_STD_DEV) &&
                       (in_rcode_reg == REQ_DESC_FETCH) &&
                       (in_value_reg[15:8] == DESC_TYPE_STRING);

    // a long quiet gap means the host re-enumerated: start the counts over
    assign gap_clear = (req_count_reg != '0) && (idle_reg > gap_ms_reg);

    // state update and result for the item in the input register
    always_comb
    begin
        logic [COUNT_W-1:0] req_base;
        logic [COUNT_W-1:0] len2_base;
        logic [COUNT_W-1:0] len4_base;
        logic [COUNT_W-1:0] len255_base;
        logic               emit;

        req_count_next   = req_count_reg;
        cnt_len2_next    = cnt_len2_reg;
        cnt_len4_next    = cnt_len4_reg;
        cnt_len255_next  = cnt_len255_reg;
        last_len_next    = last_len_reg;
        idle_next        = idle_reg;
        settle_left_next = settle_left_reg;
        settle_pend_next = settle_pend_reg;
        switched_next    = switched_reg;
        out_layer_next   = out_layer_reg;
        out_cause_next   = out_cause_reg;
        out_kind_next    = out_kind_reg;
        emit             = 1'b0;

        req_base    = gap_clear ? '0 : req_count_reg;
        len2_base   = gap_clear ? '0 : cnt_len2_reg;
        len4_base   = gap_clear ? '0 : cnt_len4_reg;
        len255_base = gap_clear ? '0 : cnt_len255_reg;

        if (advance)
        begin
            case (in_op_reg)
                OP_SETUP:
                begin
                    if (setup_hit)
                    begin
                        idle_next       = '0;
                        req_count_next  = sat_inc(req_base);
                        cnt_len2_next   = len2_base;
                        cnt_len4_next   = len4_base;
                        cnt_len255_next = len255_base;
                        if (in_len_reg == LEN_2)
                            cnt_len2_next = sat_inc(len2_base);
                        else if (in_len_reg == LEN_4)
                            cnt_len4_next = sat_inc(len4_base);
                        else if (in_len_reg == LEN_255)
                            cnt_len255_next = sat_inc(len255_base);
                        last_len_next    = in_len_reg;
                        settle_left_next = settle_ms_reg;
                        settle_pend_next = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (idle_reg != IDLE_MAX)
                        idle_next = idle_reg + IDLE_W'(1);
                    if (settle_pend_reg)
                    begin
                        if (settle_left_reg > SETTLE_W'(1))
                        begin
                            settle_left_next = settle_left_reg - SETTLE_W'(1);
                        end
                        else
                        begin
                            // settle timer expired: classify now
                            settle_left_next = '0;
                            settle_pend_next = 1'b0;
                            if (kind_c != KIND_NONE && in_conn_reg)
                            begin
                                emit           = 1'b1;
                                out_layer_next = kind_layer;
                                out_cause_next = CAUSE_DETECT;
                                out_kind_next  = kind_c;
                                switched_next  = 1'b1;
                            end
                        end
                    end
                end
                OP_DISCONNECT:
                begin
                    req_count_next   = '0;
                    cnt_len2_next    = '0;
                    cnt_len4_next    = '0;
                    cnt_len255_next  = '0;
                    last_len_next    = '0;
                    settle_left_next = '0;
                    settle_pend_next = 1'b0;
                    switched_next    = 1'b0;
                    if (revert_en_reg && switched_reg)
                    begin
                        emit           = 1'b1;
                        out_layer_next = disc_layer_reg;
                        out_cause_next = CAUSE_REVERT;
                        out_kind_next  = KIND_NONE;
                    end
                end
                default:
                begin
                    // unused operation code: ignored
                end
            endcase
        end

        // output register: load a new result, or drop one that was taken
        if (advance)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_count_reg   <= '0;
            cnt_len2_reg    <= '0;
            cnt_len4_reg    <= '0;
            cnt_len255_reg  <= '0;
            last_len_reg    <= '0;
            idle_reg        <= '0;
            settle_left_reg <= '0;
            settle_pend_reg <= 1'b0;
            switched_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            req_count_reg   <= req_count_next;
            cnt_len2_reg    <= cnt_len2_next;
            cnt_len4_reg    <= cnt_len4_next;
            cnt_len255_reg  <= cnt_len255_next;
            last_len_reg    <= last_len_next;
            idle_reg        <= idle_next;
            settle_left_reg <= settle_left_next;
            settle_pend_reg <= settle_pend_next;
            switched_reg    <= switched_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_layer_reg <= out_layer_next;
        out_cause_reg <= out_cause_next;
        out_kind_reg  <= out_kind_next;
    end

endmodule

@@ rtl/uhof_checker.sv @@
// port-level checks for the usb host os fingerprint block
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uhof_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [uhof_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [uhof_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import uhof_pkg::*;

    // a revert transfer never names a host
    `ASSERT_CLKD(a_revert_no_kind, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0] == CAUSE_REVERT) |-> (m_axis_tuser[3:1] == KIND_NONE))

    // a detection transfer always names a known host
    `ASSERT_CLKD(a_detect_has_kind, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0] == CAUSE_DETECT) |-> (m_axis_tuser[3:1] == KIND_LINUX || m_axis_tuser[3:1] == KIND_WINDOWS || m_axis_tuser[3:1] == KIND_MACOS || m_axis_tuser[3:1] == KIND_IOS))

    // a stalled result holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // no result is offered while in reset
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_axis_tvalid)

endmodule

bind usb_host_os_fingerprint uhof_checker u_uhof_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/uhof_switch_checker.sv @@
// checker that predicts and compares the layer switches of the usb host os fingerprint block
`timescale 1ns / 1ps

module uhof_switch_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uhof_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uhof_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // request_type, request_code, value_word, length_word, usb_connected, zero pad
    input  logic [uhof_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [uhof_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_layer, zero pad
    input  logic [uhof_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // cause, host_kind
    input  logic [uhof_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output int                              mismatch_count,
    output int                              pending_results
);
    import uhof_pkg::*;

    typedef struct packed {
        logic [LAYER_W-1:0] new_layer;
        logic               cause;
        kind_t              host_kind;
    } layer_switch_t;

    layer_switch_t switch_q[$];
    layer_switch_t next_switch;
    layer_switch_t want;

    // register copies
    logic [LAYER_W-1:0]  layer_macos, layer_ios, layer_windows, layer_linux, disc_layer;
    logic [SETTLE_W-1:0] settle_ms;
    logic [GAP_W-1:0]    gap_ms;
    logic                revert_en;

    // fingerprint state
    logic [COUNT_W-1:0]  req_count, n_len2, n_len4, n_len255;
    logic [LEN_W-1:0]    last_len;
    logic [IDLE_W-1:0]   idle_ms;
    logic [SETTLE_W-1:0] settle_left;
    logic                settle_pending, switched, had_switch;

    logic [7:0]          rtype, rcode;
    logic [15:0]         wvalue, wlen;
    logic                link_up;
    kind_t               kind;
    logic [LAYER_W-1:0]  got_layer;
    logic                got_cause;
    logic [2:0]          got_kind;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic clear_counts();
        req_count = '0;
        n_len2    = '0;
        n_len4    = '0;
        n_len255  = '0;
        last_len  = '0;
    endtask

    // fixed rules, first match wins
    function automatic kind_t classify_host();
        if (req_count < 8'd3)
            return KIND_NONE;
        if (n_len255 >= 8'd2 && n_len4 >= 8'd1)
            return KIND_WINDOWS;
        if (req_count == n_len255)
            return KIND_LINUX;
        if (req_count >= 8'd5 && last_len == LEN_255 && n_len255 >= 8'd1 && n_len2 >= 8'd2)
            return KIND_MACOS;
        if (req_count == 8'd4 && n_len255 == 8'd0 && n_len2 == 8'd2)
            return KIND_IOS;
        if (n_len255 == 8'd0 && n_len2 == 8'd3 && n_len4 == 8'd1)
            return KIND_LINUX;
        if (n_len255 >= 8'd1 && n_len2 == 8'd0 && n_len4 == 8'd0)
            return KIND_LINUX;
        return KIND_NONE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_macos    = '0;
            layer_ios      = '0;
            layer_windows  = '0;
            layer_linux    = '0;
            disc_layer     = '0;
            settle_ms      = SETTLE_MS_RST;
            gap_ms         = GAP_MS_RST;
            revert_en      = 1'b0;
            clear_counts();
            idle_ms        = '0;
            settle_left    = '0;
            settle_pending = 1'b0;
            switched       = 1'b0;
            switch_q.delete();
            pending_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_LAYER_MACOS:   layer_macos   = cfg_wdata[LAYER_W-1:0];
                    REG_LAYER_IOS:     layer_ios     = cfg_wdata[LAYER_W-1:0];
                    REG_LAYER_WINDOWS: layer_windows = cfg_wdata[LAYER_W-1:0];
                    REG_LAYER_LINUX:   layer_linux   = cfg_wdata[LAYER_W-1:0];
                    REG_SETTLE_MS:     settle_ms     = cfg_wdata[SETTLE_W-1:0];
                    REG_GAP_MS:        gap_ms        = cfg_wdata[GAP_W-1:0];
                    REG_REVERT_EN:     revert_en     = cfg_wdata[0];
                    REG_DISC_LAYER:    disc_layer    = cfg_wdata[LAYER_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                rtype   = s_axis_tdata[7:0];
                rcode   = s_axis_tdata[15:8];
                wvalue  = s_axis_tdata[31:16];
                wlen    = s_axis_tdata[47:32];
                link_up = s_axis_tdata[48];
                case (s_axis_tuser)
                    OP_SETUP:
                    begin
                        if (rtype == REQ_TYPE_IN_STD_DEV && rcode == REQ_DESC_FETCH
                            && wvalue[15:8] == DESC_TYPE_STRING)
                        begin
                            // long quiet gap means the host enumerates afresh
                            if (req_count != '0 && idle_ms > gap_ms)
                                clear_counts();
                            idle_ms = '0;
                            if (req_count != COUNT_MAX)
                                req_count++;
                            if (wlen == LEN_2)
                            begin
                                if (n_len2 != COUNT_MAX)
                                    n_len2++;
                            end
                            else if (wlen == LEN_4)
                            begin
                                if (n_len4 != COUNT_MAX)
                                    n_len4++;
                            end
                            else if (wlen == LEN_255)
                            begin
                                if (n_len255 != COUNT_MAX)
                                    n_len255++;
                            end
                            last_len       = wlen;
                            settle_left    = settle_ms;
                            settle_pending = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        if (idle_ms != IDLE_MAX)
                            idle_ms++;
                        if (settle_pending)
                        begin
                            if (settle_left > SETTLE_W'(1))
                                settle_left--;
                            else
                            begin
                                settle_left    = '0;
                                settle_pending = 1'b0;
                                kind = classify_host();
                                if (kind != KIND_NONE && link_up)
                                begin
                                    case (kind)
                                        KIND_MACOS:   next_switch.new_layer = layer_macos;
                                        KIND_IOS:     next_switch.new_layer = layer_ios;
                                        KIND_WINDOWS: next_switch.new_layer = layer_windows;
                                        default:      next_switch.new_layer = layer_linux;
                                    endcase
                                    next_switch.cause     = CAUSE_DETECT;
                                    next_switch.host_kind = kind;
                                    switch_q.push_back(next_switch);
                                    switched = 1'b1;
                                end
                            end
                        end
                    end
                    OP_DISCONNECT:
                    begin
                        had_switch     = switched;
                        clear_counts();
                        settle_left    = '0;
                        settle_pending = 1'b0;
                        switched       = 1'b0;
                        if (revert_en && had_switch)
                        begin
                            next_switch.new_layer = disc_layer;
                            next_switch.cause     = CAUSE_REVERT;
                            next_switch.host_kind = KIND_NONE;
                            switch_q.push_back(next_switch);
                        end
                    end
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_layer = m_axis_tdata[LAYER_W-1:0];
                got_cause = m_axis_tuser[0];
                got_kind  = m_axis_tuser[3:1];
                if (switch_q.size() == 0)
                    report_mismatch($sformatf("result with none expected: layer %0d cause %0d kind %0d",
                                              got_layer, got_cause, got_kind));
                else
                begin
                    want = switch_q.pop_front();
                    if (got_layer != want.new_layer)
                        report_mismatch($sformatf("new_layer %0d, expected %0d",
                                                  got_layer, want.new_layer));
                    if (got_cause != want.cause)
                        report_mismatch($sformatf("cause %0d, expected %0d",
                                                  got_cause, want.cause));
                    if (got_kind != want.host_kind)
                        report_mismatch($sformatf("host_kind %0d, expected %0d",
                                                  got_kind, want.host_kind));
                end
            end

            pending_results = switch_q.size();
        end
    end

endmodule

@@ tb/usb_host_os_fingerprint_tb.sv @@
// top of the usb host os fingerprint testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module usb_host_os_fingerprint_tb;
    import uhof_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 8;
    // output register plus input register, with margin
    localparam int QUIET_CYCLES   = 6;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;

    // operation code the block has no use for
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // request_type, request_code, value_word, length_word, usb_connected, zero pad
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    // operation
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // new_layer, zero pad
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // cause, host_kind
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    int mismatch_count;
    int pending_results;

    // idling percentages for the sender and receiver sides
    int send_idle_pct = 24;
    int recv_idle_pct = 62;
    bit hold_off_armed = 1'b0;

    int items_sent = 0;
    // settle time currently programmed, to size the tick runs
    int settle_now = 200;
    int stall_cycles;

    always #(HALF_PERIOD) clk = ~clk;

    usb_host_os_fingerprint dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    uhof_switch_checker switch_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // one slave transfer; entered and left at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] rtype,
                             input logic [7:0] rcode, input logic [15:0] wvalue,
                             input logic [15:0] wlen, input logic link_up);
        // random gap before the item, valid low meanwhile
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({link_up, wlen, wvalue, rcode, rtype});
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // well-formed string descriptor request of the given length
    task automatic send_request(input logic [LEN_W-1:0] len);
        send_item(OP_SETUP, REQ_TYPE_IN_STD_DEV, REQ_DESC_FETCH,
                  {DESC_TYPE_STRING, 8'($urandom())}, len, 1'($urandom()));
    endtask

    // millisecond tick; the other fields carry junk the block must ignore
    task automatic send_tick(input logic link_up);
        send_item(OP_TICK, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                  16'($urandom()), link_up);
    endtask

    task automatic send_disconnect();
        send_item(OP_DISCONNECT, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                  16'($urandom()), 1'($urandom()));
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // writes all eight registers back to back, only while the block is idle
    task automatic program_regs(input logic [LAYER_W-1:0] mac, input logic [LAYER_W-1:0] ios,
                                input logic [LAYER_W-1:0] win, input logic [LAYER_W-1:0] lin,
                                input logic [SETTLE_W-1:0] settle, input logic [GAP_W-1:0] gap,
                                input logic rev, input logic [LAYER_W-1:0] disc);
        put_reg(REG_LAYER_MACOS,   CFG_DATA_W'(mac));
        put_reg(REG_LAYER_IOS,     CFG_DATA_W'(ios));
        put_reg(REG_LAYER_WINDOWS, CFG_DATA_W'(win));
        put_reg(REG_LAYER_LINUX,   CFG_DATA_W'(lin));
        put_reg(REG_SETTLE_MS,     settle);
        put_reg(REG_GAP_MS,        CFG_DATA_W'(gap));
        put_reg(REG_REVERT_EN,     CFG_DATA_W'(rev));
        put_reg(REG_DISC_LAYER,    CFG_DATA_W'(disc));
        cfg_we     <= 1'b0;
        settle_now = int'(settle);
    endtask

    // wait until every expected switch is out, then let the pipeline empty
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // lengths that matter to the rules, plus arbitrary ones
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(3))
            0:       return LEN_2;
            1:       return LEN_4;
            2:       return LEN_255;
            default: return 16'($urandom());
        endcase
    endfunction

    // one enumeration: a run of string requests shaped after a host, then the
    // settle ticks, sometimes followed by a disconnect
    task automatic run_enumeration();
        logic [LEN_W-1:0] lens[$];
        int n_ticks;
        case ($urandom_range(5))
            0:
            begin
                // windows shape: two 255s and a 4
                lens = '{LEN_255, LEN_255, LEN_4};
                repeat ($urandom_range(2))
                    lens.insert($urandom_range(lens.size()), pick_length());
            end
            1:
            begin
                // linux shape: nothing but 255s
                repeat ($urandom_range(3, 5))
                    lens.push_back(LEN_255);
            end
            2:
            begin
                // macos shape: two 2s, filler, ending on 255
                lens = '{LEN_2, LEN_2};
                repeat ($urandom_range(2, 4))
                    lens.insert($urandom_range(lens.size()), pick_length());
                lens.push_back(LEN_255);
            end
            3:
            begin
                // ios shape: four requests, two of them 2
                lens = '{LEN_2, LEN_2};
                repeat (2)
                    lens.insert($urandom_range(lens.size()),
                                ($urandom_range(3) == 0) ? LEN_4 : 16'($urandom()));
            end
            4:
            begin
                // the other linux shape: three 2s and one 4
                lens = '{LEN_2, LEN_2, LEN_2};
                lens.insert($urandom_range(3), LEN_4);
            end
            default:
            begin
                repeat ($urandom_range(1, 7))
                    lens.push_back(pick_length());
            end
        endcase
        foreach (lens[i])
        begin
            send_request(lens[i]);
            // stray ticks inside the run hit the gap test and early expiry
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) send_tick(1'b1);
        end
        // let the timer run out, a little past it at times, when settle is at most 16
        n_ticks = (settle_now <= 16) ? settle_now + int'($urandom_range(2))
                                     : int'($urandom_range(1, 8));
        repeat (n_ticks) send_tick($urandom_range(7) != 0);
        if ($urandom_range(2) == 0)
            send_disconnect();
    endtask

    // malformed setups, unused operation, lone ticks and disconnects
    task automatic run_noise();
        case ($urandom_range(6))
            0: send_item(OP_UNUSED, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                         16'($urandom()), 1'($urandom()));
            1: send_item(OP_SETUP, 8'($urandom()), REQ_DESC_FETCH,
                         {DESC_TYPE_STRING, 8'($urandom())}, pick_length(), 1'($urandom()));
            2: send_item(OP_SETUP, REQ_TYPE_IN_STD_DEV, 8'($urandom()),
                         {DESC_TYPE_STRING, 8'($urandom())}, pick_length(), 1'($urandom()));
            3: send_item(OP_SETUP, REQ_TYPE_IN_STD_DEV, REQ_DESC_FETCH,
                         16'($urandom()), pick_length(), 1'($urandom()));
            4: send_item(OP_SETUP, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                         16'($urandom()), 1'($urandom()));
            5: send_tick(1'($urandom()));
            default: send_disconnect();
        endcase
    endtask

    // mostly enumerations, some noise, until the running item total is reached
    task automatic run_random(input int upto);
        while (items_sent < upto)
        begin
            if ($urandom_range(3) != 0)
                run_enumeration();
            else
                run_noise();
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("usb_host_os_fingerprint regression: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SETUP;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme layers, shortest settle, a gap one below the largest, revert on
        program_regs(5'd31, 5'd1, 5'd2, 5'd0, 16'd1, 12'd4094, 1'b1, 5'd31);
        // unused operation and a setup that matches nothing, all ones
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(OP_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // windows, then revert on disconnect
        send_request(LEN_255);
        send_request(LEN_255);
        send_request(LEN_4);
        send_tick(1'b1);
        send_disconnect();
        // macos: two 2s, last request 255
        send_request(LEN_2);
        send_request(LEN_2);
        send_request(LEN_255);
        send_request(LEN_255);
        send_request(LEN_255);
        send_tick(1'b1);
        send_disconnect();
        // ios: four requests, two 2s, extreme other lengths
        send_request(LEN_2);
        send_request(LEN_2);
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_tick(1'b1);
        send_disconnect();
        // linux but the link is down at expiry: nothing, and no revert after
        send_request(LEN_255);
        send_request(LEN_255);
        send_request(LEN_255);
        send_tick(1'b0);
        send_disconnect();
        wait_quiet();

        // sender idles little, receiver a lot
        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'($urandom_range(1, 6)), 12'd4094, 1'b1, 5'($urandom()));
        run_random(245);
        wait_quiet();

        // shortest gap: any two quiet ticks restart the count
        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'($urandom_range(1, 3)), 12'd1, 1'b0, 5'd0);
        run_random(465);
        wait_quiet();

        // now the sender idles a lot, the receiver little
        send_idle_pct = 62;
        recv_idle_pct = 24;

        // longest settle: the timer never runs out in this stretch
        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'd65535, 12'($urandom_range(100, 4094)), 1'b1, 5'($urandom()));
        run_random(525);
        wait_quiet();

        // short gaps against short settle times
        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'($urandom_range(1, 8)), 12'($urandom_range(2, 40)), 1'b1,
                     5'($urandom()));
        run_random(745);
        wait_quiet();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // back-pressure: receiver holds off while two results per round pile up
        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'd1, 12'd4094, 1'b1, 5'($urandom()));
        hold_off_armed = 1'b1;
        repeat (12)
        begin
            repeat (3) send_request(LEN_255);
            send_tick(1'b1);
            send_disconnect();
        end
        run_random(905);
        wait_quiet();

        program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     16'($urandom_range(1, 8)), 12'($urandom_range(1, 4094)),
                     1'($urandom()), 5'($urandom()));
        run_random(1125);
        wait_quiet();

        if (mismatch_count == 0)
            $display("usb_host_os_fingerprint regression: pass");
        else
            $display("usb_host_os_fingerprint regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/uhof_pkg.sv
rtl/usb_host_os_fingerprint.sv
rtl/uhof_checker.sv
tb/uhof_switch_checker.sv
tb/usb_host_os_fingerprint_tb.sv
